### hdl/rrt_pkg.sv
package rrt_pkg;
  localparam int Entries = 64;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);
  localparam int PosW = 6;
  localparam int ResultCap = 64;

  localparam logic [2:0] CmdAdd = 3'd0;
  localparam logic [2:0] CmdSetProg = 3'd1;
  localparam logic [2:0] CmdEdit = 3'd2;
  localparam logic [2:0] CmdFind = 3'd3;
  localparam logic [2:0] CmdSort = 3'd4;
  localparam logic [2:0] CmdDelete = 3'd5;
  localparam logic [2:0] CmdList = 3'd6;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StBadIndex = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StFull = 3'd3;
  localparam logic [2:0] StEmpty = 3'd4;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] entry_index;
    logic [63:0] name_tag;
    logic signed [15:0] new_progress;
  } req_t;

  typedef struct packed {
    logic [2:0] status_code;
    logic [5:0] position;
    logic [63:0] out_name_tag;
    logic signed [15:0] out_progress;
    logic complete;
    logic last;
  } rsp_t;

  typedef struct packed {
    logic [63:0] name;
    logic signed [15:0] prog;
    logic done;
  } rec_t;

  // controller to datapath
  typedef enum logic [3:0] {
    OpNone, OpLoad, OpWrite, OpRdI, OpRdJ, OpWrI, OpWrJ, OpShift, OpCount
  } op_t;

  typedef struct packed {
    op_t op;
    logic [IdxW-1:0] addr;
    logic cnt_inc;
    logic cnt_dec;
  } ctl_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic name_hit;
    logic j_greater;
    rec_t rd;
  } sts_t;
endpackage

### hdl/rrt_req_if.sv
interface rrt_req_if;
  logic valid;
  logic ready;
  rrt_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/rrt_rsp_if.sv
interface rrt_rsp_if;
  logic valid;
  logic ready;
  rrt_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/rrt_datapath.sv
module rrt_datapath (
  input  logic clk,
  input  logic rst_n,
  input  rrt_pkg::ctl_t ctl,
  input  rrt_pkg::req_t req,
  input  logic signed [15:0] thr,
  output rrt_pkg::sts_t sts
);
  rrt_pkg::rec_t mem [rrt_pkg::Entries];
  rrt_pkg::rec_t rd_r;
  rrt_pkg::rec_t ri_r;
  logic [rrt_pkg::CntW-1:0] count_r;
  rrt_pkg::rec_t wr;
  logic [rrt_pkg::IdxW-1:0] wa;
  logic we;

  always_comb begin
    wr = '0;
    wr.name = (req.cmd == rrt_pkg::CmdSetProg) ? rd_r.name : req.name_tag;
    wr.prog = req.new_progress;
    wr.done = (req.new_progress >= thr);
    wa = ctl.addr;
    we = 1'b0;
    case (ctl.op)
      rrt_pkg::OpWrite: we = 1'b1;
      rrt_pkg::OpWrI: begin we = 1'b1; wr = rd_r; end
      rrt_pkg::OpWrJ: begin we = 1'b1; wr = ri_r; end
      rrt_pkg::OpShift: begin we = 1'b1; wr = rd_r; end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wr;
    rd_r <= mem[ctl.addr];
    if (ctl.op == rrt_pkg::OpRdI) ri_r <= rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.cnt_inc) begin
      count_r <= count_r + 1'b1;
    end else if (ctl.cnt_dec) begin
      count_r <= count_r - 1'b1;
    end
  end

  assign sts.count = count_r;
  assign sts.rd = rd_r;
  assign sts.name_hit = (rd_r.name == req.name_tag);
  assign sts.j_greater = (rd_r.prog > ri_r.prog);
endmodule

### hdl/rrt_ctrl.sv
module rrt_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  rrt_pkg::req_t in_req,
  output rrt_pkg::req_t req_r,
  output rrt_pkg::ctl_t ctl,
  input  rrt_pkg::sts_t sts,
  output logic out_valid,
  input  logic out_ready,
  output rrt_pkg::rsp_t out_rsp
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WR, S_FIND, S_SI, S_SJ, S_SCMP, S_SWI, S_SWJ,
    S_DEL, S_SHR, S_SHW, S_LST, S_OUT
  } state_t;

  localparam int IW = rrt_pkg::IdxW;
  localparam int CW = rrt_pkg::CntW;

  state_t state_r;
  logic [CW-1:0] i_r, j_r, lim_r;
  logic after_r;
  logic ovalid_r;
  rrt_pkg::rsp_t rsp_r;
  logic accept;
  logic emit;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_rsp = rsp_r;

  function automatic rrt_pkg::rsp_t err(input logic [2:0] st);
    rrt_pkg::rsp_t r;
    r = '0;
    r.status_code = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic rrt_pkg::rsp_t rec(input logic [CW-1:0] p, input rrt_pkg::rec_t d,
                                        input logic lst);
    rrt_pkg::rsp_t r;
    r.status_code = rrt_pkg::StOk;
    r.position = p[rrt_pkg::PosW-1:0];
    r.out_name_tag = d.name;
    r.out_progress = d.prog;
    r.complete = d.done;
    r.last = lst;
    return r;
  endfunction

  always_comb begin
    case (state_r)
      S_LST: emit = after_r && (!ovalid_r || out_ready);
      S_DEL: emit = !after_r;
      S_OUT: emit = !ovalid_r || out_ready;
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.op = rrt_pkg::OpNone;
    ctl.addr = i_r[IW-1:0];
    case (state_r)
      S_IDLE: ctl.addr = in_req.entry_index[IW-1:0];
      S_RD: ctl.addr = req_r.entry_index[IW-1:0];
      S_WR: begin
        ctl.op = rrt_pkg::OpWrite;
        ctl.cnt_inc = (req_r.cmd == rrt_pkg::CmdAdd);
      end
      S_SI: ctl.addr = i_r[IW-1:0];
      S_SJ: begin ctl.op = rrt_pkg::OpRdI; ctl.addr = j_r[IW-1:0]; end
      S_SCMP: ctl.addr = j_r[IW-1:0];
      S_SWI: begin ctl.op = rrt_pkg::OpWrI; ctl.addr = i_r[IW-1:0]; end
      S_SWJ: begin ctl.op = rrt_pkg::OpWrJ; ctl.addr = j_r[IW-1:0]; end
      S_SHR: ctl.addr = j_r[IW-1:0];
      S_SHW: ctl.op = rrt_pkg::OpShift;
      S_DEL: ctl.cnt_dec = (i_r + 1'b1 >= sts.count);
      default: ctl.op = rrt_pkg::OpNone;
    endcase
  end

  // sort: i_r outer, j_r inner; S_SI reads i then j pipelined
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (emit) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (accept) begin
          req_r <= in_req;
          i_r <= '0;
          case (in_req.cmd)
            rrt_pkg::CmdAdd: begin
              if (sts.count == CW'(rrt_pkg::Entries)) begin
                rsp_r <= err(rrt_pkg::StFull); state_r <= S_OUT;
              end else begin
                i_r <= sts.count; state_r <= S_WR;
              end
            end
            rrt_pkg::CmdSetProg, rrt_pkg::CmdEdit, rrt_pkg::CmdDelete: begin
              if (CW'(in_req.entry_index) >= sts.count) begin
                rsp_r <= err(rrt_pkg::StBadIndex); state_r <= S_OUT;
              end else begin
                i_r <= CW'(in_req.entry_index); state_r <= S_RD;
              end
            end
            rrt_pkg::CmdFind: state_r <= S_FIND;
            rrt_pkg::CmdSort, rrt_pkg::CmdList: begin
              lim_r <= (sts.count > CW'(rrt_pkg::ResultCap)) ?
                       CW'(rrt_pkg::ResultCap) : sts.count;
              if (sts.count == '0) begin
                rsp_r <= err(rrt_pkg::StEmpty); state_r <= S_OUT;
              end else if (in_req.cmd == rrt_pkg::CmdSort && sts.count > 1) begin
                j_r <= CW'(1); state_r <= S_SI;
              end else begin
                state_r <= S_LST;
              end
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_RD: state_r <= (req_r.cmd == rrt_pkg::CmdDelete) ? S_DEL : S_WR;
        S_WR: state_r <= S_LST;
        S_FIND: begin
          // rd_r holds entry i_r here once after_r is set
          if (i_r >= sts.count) begin
            rsp_r <= err(rrt_pkg::StNotFound); state_r <= S_OUT;
          end else if (after_r && sts.name_hit) begin
            rsp_r <= rec(i_r, sts.rd, 1'b1); state_r <= S_OUT;
          end else if (after_r) begin
            i_r <= i_r + 1'b1; after_r <= 1'b0;
          end else begin
            after_r <= 1'b1;
          end
        end
        S_SI: state_r <= S_SJ;
        S_SJ: state_r <= S_SCMP;
        S_SCMP: begin
          if (sts.j_greater) state_r <= S_SWI;
          else if (j_r + 1'b1 < sts.count) begin
            j_r <= j_r + 1'b1; state_r <= S_SI;
          end else if (i_r + CW'(2) < sts.count) begin
            i_r <= i_r + 1'b1; j_r <= i_r + CW'(2); state_r <= S_SI;
          end else begin
            i_r <= '0; state_r <= S_LST;
          end
        end
        S_SWI: state_r <= S_SWJ;
        S_SWJ: begin
          if (j_r + 1'b1 < sts.count) begin
            j_r <= j_r + 1'b1; state_r <= S_SI;
          end else if (i_r + CW'(2) < sts.count) begin
            i_r <= i_r + 1'b1; j_r <= i_r + CW'(2); state_r <= S_SI;
          end else begin
            i_r <= '0; state_r <= S_LST;
          end
        end
        S_DEL: begin
          if (!after_r) rsp_r <= rec(i_r, sts.rd, 1'b1);
          if (i_r + 1'b1 >= sts.count) begin
            after_r <= 1'b0; state_r <= S_IDLE;
          end else begin
            after_r <= 1'b1; j_r <= i_r + 1'b1; state_r <= S_SHR;
          end
        end
        S_SHR: state_r <= S_SHW;
        S_SHW: begin i_r <= j_r; state_r <= S_DEL; end
        S_LST: begin
          // wait for the registered read; after_r marks data ready
          if (!after_r) after_r <= 1'b1;
          else if (emit) begin
            after_r <= 1'b0;
            if (req_r.cmd == rrt_pkg::CmdSort || req_r.cmd == rrt_pkg::CmdList) begin
              rsp_r <= rec(i_r, sts.rd, i_r + 1'b1 == lim_r);
              if (i_r + 1'b1 == lim_r) state_r <= S_IDLE;
              else i_r <= i_r + 1'b1;
            end else begin
              rsp_r <= rec(i_r, sts.rd, 1'b1);
              state_r <= S_IDLE;
            end
          end
        end
        S_OUT: if (emit) begin
          after_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_IDLE) after_r <= 1'b0;
    end
  end
endmodule

### hdl/ranked_record_table.sv
// channel | dir | payload
// in      | in  | cmd, entry_index, name_tag, new_progress
// out     | out | status_code, position, out_name_tag, out_progress, complete, last
// cfg     | in  | done_threshold (write only)
// One command at a time; a new request waits until the last result is taken.
// Add writes the record and reads it back; edit reads, writes and reads it back;
// find compares each record in turn; delete shifts each later record down; sort
// compares each pair and swaps; listing sends the records in turn, holding on output stalls.
// Memory has one read port.
// Reset clears count, threshold (100) and controller state; records stay undefined.
module ranked_record_table (
  input logic clk,
  input logic rst_n,
  rrt_req_if.sink in_ch,
  rrt_rsp_if.source out_ch,
  input logic cfg_we,
  input logic [15:0] cfg_wdata
);
  logic signed [15:0] thr_r;
  rrt_pkg::req_t req_r;
  rrt_pkg::ctl_t ctl;
  rrt_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= 16'sd100;
    else if (cfg_we) thr_r <= cfg_wdata;
  end

  rrt_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req(in_ch.payload),
    .req_r, .ctl, .sts,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rsp(out_ch.payload)
  );

  rrt_datapath u_dp (.clk, .rst_n, .ctl, .req(req_r), .thr(thr_r), .sts);

`ifndef ASSERT_OFF
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.payload.status_code != rrt_pkg::StOk |-> out_ch.payload.last)
    else $error("error result without last");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
    else $error("result changed while stalled");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= rrt_pkg::CntW'(rrt_pkg::Entries))
    else $error("count overflow");
`endif
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  localparam logic [2:0] CmdUnused = 3'd7;
  localparam int WatchdogLimit = 40000;
  localparam int DrainCycles = 40;
  localparam int PressureCycles = 600;

  typedef struct {
    rrt_pkg::req_t req;
    bit typed;
    rrt_pkg::rsp_t rsp;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  rrt_req_if in_if ();
  rrt_rsp_if out_if ();

  ranked_record_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  logic [63:0] rec_name [rrt_pkg::Entries];
  logic signed [15:0] rec_prog [rrt_pkg::Entries];
  logic rec_done [rrt_pkg::Entries];
  int rec_count;
  logic signed [15:0] done_level;

  rrt_pkg::rsp_t expected_rsp [$];
  stim_row_t stim_rows [$];
  int mismatches;
  int rsp_seen;
  int idle_cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic rrt_pkg::rsp_t mk_rsp(logic [2:0] st, logic [5:0] pos, logic [63:0] tag,
                                           logic signed [15:0] prog, logic comp, logic lst);
    rrt_pkg::rsp_t r;
    r.status_code = st;
    r.position = pos;
    r.out_name_tag = tag;
    r.out_progress = prog;
    r.complete = comp;
    r.last = lst;
    return r;
  endfunction

  function automatic rrt_pkg::req_t mk_req(logic [2:0] c, logic [5:0] idx, logic [63:0] tag,
                                           logic signed [15:0] prog);
    rrt_pkg::req_t r;
    r.cmd = c;
    r.entry_index = idx;
    r.name_tag = tag;
    r.new_progress = prog;
    return r;
  endfunction

  function automatic void add_row(rrt_pkg::req_t r, bit typed, rrt_pkg::rsp_t rsp);
    stim_row_t s;
    s.req = r;
    s.typed = typed;
    s.rsp = rsp;
    stim_rows.push_back(s);
  endfunction

  function automatic rrt_pkg::rsp_t record_rsp(int i, logic lst);
    return mk_rsp(rrt_pkg::StOk, i[5:0], rec_name[i], rec_prog[i], rec_done[i], lst);
  endfunction

  function automatic void push_listing();
    int n;
    if (rec_count == 0) begin
      expected_rsp.push_back(mk_rsp(rrt_pkg::StEmpty, 0, 0, 0, 0, 1));
      return;
    end
    n = (rec_count > rrt_pkg::ResultCap) ? rrt_pkg::ResultCap : rec_count;
    for (int i = 0; i < n; i++) begin
      expected_rsp.push_back(record_rsp(i, i + 1 == n));
    end
  endfunction

  function automatic void table_command(rrt_pkg::req_t r);
    int hit;
    logic [63:0] tn;
    logic signed [15:0] tp;
    logic td;
    hit = -1;
    case (r.cmd)
      rrt_pkg::CmdAdd: begin
        if (rec_count >= rrt_pkg::Entries) begin
          expected_rsp.push_back(mk_rsp(rrt_pkg::StFull, 0, 0, 0, 0, 1));
        end else begin
          rec_name[rec_count] = r.name_tag;
          rec_prog[rec_count] = r.new_progress;
          rec_done[rec_count] = r.new_progress >= done_level;
          expected_rsp.push_back(record_rsp(rec_count, 1));
          rec_count++;
        end
      end
      rrt_pkg::CmdSetProg, rrt_pkg::CmdEdit: begin
        if (r.entry_index >= rec_count) begin
          expected_rsp.push_back(mk_rsp(rrt_pkg::StBadIndex, 0, 0, 0, 0, 1));
        end else begin
          if (r.cmd == rrt_pkg::CmdEdit) rec_name[r.entry_index] = r.name_tag;
          rec_prog[r.entry_index] = r.new_progress;
          rec_done[r.entry_index] = r.new_progress >= done_level;
          expected_rsp.push_back(record_rsp(r.entry_index, 1));
        end
      end
      rrt_pkg::CmdFind: begin
        for (int i = 0; i < rec_count; i++) begin
          if (hit < 0 && rec_name[i] == r.name_tag) hit = i;
        end
        if (hit < 0) expected_rsp.push_back(mk_rsp(rrt_pkg::StNotFound, 0, 0, 0, 0, 1));
        else expected_rsp.push_back(record_rsp(hit, 1));
      end
      rrt_pkg::CmdSort: begin
        for (int i = 0; i + 1 < rec_count; i++) begin
          for (int j = i + 1; j < rec_count; j++) begin
            if (rec_prog[j] > rec_prog[i]) begin
              tn = rec_name[i];
              tp = rec_prog[i];
              td = rec_done[i];
              rec_name[i] = rec_name[j];
              rec_prog[i] = rec_prog[j];
              rec_done[i] = rec_done[j];
              rec_name[j] = tn;
              rec_prog[j] = tp;
              rec_done[j] = td;
            end
          end
        end
        push_listing();
      end
      rrt_pkg::CmdDelete: begin
        if (r.entry_index >= rec_count) begin
          expected_rsp.push_back(mk_rsp(rrt_pkg::StBadIndex, 0, 0, 0, 0, 1));
        end else begin
          expected_rsp.push_back(record_rsp(r.entry_index, 1));
          for (int i = r.entry_index; i + 1 < rec_count; i++) begin
            rec_name[i] = rec_name[i + 1];
            rec_prog[i] = rec_prog[i + 1];
            rec_done[i] = rec_done[i + 1];
          end
          rec_count--;
        end
      end
      rrt_pkg::CmdList: push_listing();
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] pick_tag();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return rec_count > 0 ? rec_name[$urandom_range(0, rec_count - 1)] : 64'd0;
      2: return (64'($urandom_range(0, 7)) << 60) | 64'($urandom_range(0, 3));
      default: return {$urandom, $urandom} ^ {32'hFFFF_FFFF, 32'h0};
    endcase
  endfunction

  function automatic logic signed [15:0] pick_prog();
    case ($urandom_range(0, 6))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return done_level;
      3: return done_level - 16'sd1;
      4: return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rrt_pkg::req_t pick_req(bit fill);
    logic [2:0] c;
    logic [5:0] idx;
    int w;
    w = $urandom_range(0, 99);
    if (fill) c = (w < 75) ? rrt_pkg::CmdAdd : 3'($urandom_range(1, 7));
    else if (w < 25) c = rrt_pkg::CmdAdd;
    else if (w < 97) c = 3'($urandom_range(1, 6));
    else c = CmdUnused;
    if (rec_count > 0 && $urandom_range(0, 3) != 0) idx = 6'($urandom_range(0, rec_count - 1));
    else idx = 6'($urandom);
    return mk_req(c, idx, pick_tag(), pick_prog());
  endfunction

  task automatic send_req(rrt_pkg::req_t r, bit typed, rrt_pkg::rsp_t rsp, bit no_gaps);
    int gap;
    in_if.payload <= r;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    table_command(r);
    if (typed) begin
      void'(expected_rsp.pop_back());
      expected_rsp.push_back(rsp);
    end
    gap = 0;
    if (!no_gaps) begin
      if ($urandom_range(0, 11) == 0) gap = $urandom_range(15, 80);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle_and_config(logic signed [15:0] level);
    in_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    do @(posedge clk); while (!in_if.ready);
    repeat (DrainCycles) @(posedge clk);
    cfg_wdata <= level;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    done_level = level;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      rsp_seen <= rsp_seen + 1;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", out_if.payload);
      end else begin
        rrt_pkg::rsp_t e;
        e = expected_rsp.pop_front();
        if (e.status_code !== out_if.payload.status_code ||
            e.position !== out_if.payload.position ||
            e.out_name_tag !== out_if.payload.out_name_tag ||
            e.out_progress !== out_if.payload.out_progress ||
            e.complete !== out_if.payload.complete ||
            e.last !== out_if.payload.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_if.payload);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    bit held;
    int gap;
    held = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held && rsp_seen >= 30) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (PressureCycles) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      gap = 0;
      if ($urandom_range(0, 13) == 0) gap = $urandom_range(10, 60);
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
      if (gap > 0 && (rsp_seen / 50) % 3 != 2) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    logic signed [15:0] levels [4];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 16'd0;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    mismatches = 0;
    rsp_seen = 0;
    idle_cycles = 0;
    rec_count = 0;
    done_level = 16'sd100;
    for (int i = 0; i < rrt_pkg::Entries; i++) begin
      rec_name[i] = '0;
      rec_prog[i] = '0;
      rec_done[i] = 1'b0;
    end

    add_row(mk_req(rrt_pkg::CmdList, 0, 0, 0), 1, mk_rsp(rrt_pkg::StEmpty, 0, 0, 0, 0, 1));
    add_row(mk_req(rrt_pkg::CmdSort, 0, 0, 0), 1, mk_rsp(rrt_pkg::StEmpty, 0, 0, 0, 0, 1));
    add_row(mk_req(rrt_pkg::CmdFind, 0, 64'd7, 0), 1,
            mk_rsp(rrt_pkg::StNotFound, 0, 0, 0, 0, 1));
    add_row(mk_req(rrt_pkg::CmdSetProg, 0, 0, 16'sd5), 1,
            mk_rsp(rrt_pkg::StBadIndex, 0, 0, 0, 0, 1));
    add_row(mk_req(rrt_pkg::CmdEdit, 6'd63, '1, 16'sd5), 1,
            mk_rsp(rrt_pkg::StBadIndex, 0, 0, 0, 0, 1));
    add_row(mk_req(rrt_pkg::CmdDelete, 0, 0, 0), 1,
            mk_rsp(rrt_pkg::StBadIndex, 0, 0, 0, 0, 1));
    add_row(mk_req(rrt_pkg::CmdAdd, 6'd63, '1, 16'sh7FFF), 1,
            mk_rsp(rrt_pkg::StOk, 0, '1, 16'sh7FFF, 1, 1));
    add_row(mk_req(rrt_pkg::CmdAdd, 0, 0, 16'sh8000), 1,
            mk_rsp(rrt_pkg::StOk, 1, 0, 16'sh8000, 0, 1));
    add_row(mk_req(rrt_pkg::CmdAdd, 0, 64'd5, 16'sd100), 1,
            mk_rsp(rrt_pkg::StOk, 2, 64'd5, 16'sd100, 1, 1));
    add_row(mk_req(rrt_pkg::CmdAdd, 0, 64'd6, 16'sd99), 1,
            mk_rsp(rrt_pkg::StOk, 3, 64'd6, 16'sd99, 0, 1));
    add_row(mk_req(rrt_pkg::CmdSetProg, 1, 64'hAAAA, 16'sd100), 1,
            mk_rsp(rrt_pkg::StOk, 1, 0, 16'sd100, 1, 1));
    add_row(mk_req(rrt_pkg::CmdEdit, 0, 64'h1234, -16'sd1), 1,
            mk_rsp(rrt_pkg::StOk, 0, 64'h1234, -16'sd1, 0, 1));
    add_row(mk_req(rrt_pkg::CmdFind, 0, 64'd5, 0), 1,
            mk_rsp(rrt_pkg::StOk, 2, 64'd5, 16'sd100, 1, 1));
    add_row(mk_req(rrt_pkg::CmdFind, 0, 64'hDEAD, 0), 1,
            mk_rsp(rrt_pkg::StNotFound, 0, 0, 0, 0, 1));
    add_row(mk_req(rrt_pkg::CmdAdd, 0, 64'd5, 16'sd100), 1,
            mk_rsp(rrt_pkg::StOk, 4, 64'd5, 16'sd100, 1, 1));
    add_row(mk_req(rrt_pkg::CmdFind, 0, 64'd5, 0), 1,
            mk_rsp(rrt_pkg::StOk, 2, 64'd5, 16'sd100, 1, 1));
    add_row(mk_req(rrt_pkg::CmdSort, 0, 0, 0), 0, '0);
    add_row(mk_req(rrt_pkg::CmdList, 0, 0, 0), 0, '0);
    add_row(mk_req(rrt_pkg::CmdDelete, 0, 0, 0), 0, '0);
    add_row(mk_req(rrt_pkg::CmdDelete, 6'd63, 0, 0), 1,
            mk_rsp(rrt_pkg::StBadIndex, 0, 0, 0, 0, 1));
    add_row(mk_req(CmdUnused, 6'd21, '1, 16'sh7FFF), 0, '0);
    add_row(mk_req(rrt_pkg::CmdSetProg, 6'd4, 0, 0), 1,
            mk_rsp(rrt_pkg::StBadIndex, 0, 0, 0, 0, 1));
    add_row(mk_req(rrt_pkg::CmdList, 0, 0, 0), 0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[k]) begin
      send_req(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].rsp, 1'b0);
    end

    levels[0] = 16'sh8000;
    levels[1] = 16'sh7FFF;
    levels[2] = 16'($urandom);
    levels[3] = 16'sd0;
    for (int p = 0; p < 4; p++) begin
      settle_and_config(levels[p]);
      for (int n = 0; n < (p == 1 ? 95 : 54); n++) begin
        send_req(pick_req(p == 1), 1'b0, '0, p == 2 && n < 30);
      end
    end
    settle_and_config(16'sd100);
    send_req(mk_req(rrt_pkg::CmdList, 0, 0, 0), 1'b0, '0, 1'b0);
    in_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
